FILE: src/tun_pkg.sv
package tun_pkg;

  localparam int CW = 16;   // vertex coordinate width
  localparam int EW = 17;   // edge component width
  localparam int PW = 34;   // cross magnitude width
  localparam int MW = 30;   // normalized magnitude width
  localparam int SW = 62;   // sum of squares width
  localparam int RW = 31;   // root width
  localparam int QW = 15;   // quotient width
  localparam int OW = 16;   // output component width
  localparam int FB = 14;   // output fraction bits
  localparam int NW = MW + FB + 1;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << FB;

  // word moving through the square root cells
  typedef struct packed {
    logic                   vld;
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0][MW-1:0]     mag;
    logic [SW-1:0]          rad;
    logic [RW+2:0]          rem;
    logic [RW-1:0]          root;
  } tun_sqrt_t;

  // word moving through the divider cells
  typedef struct packed {
    logic                   vld;
    logic                   degen;
    logic [2:0]             neg;
    logic [RW-1:0]          den;
    logic [2:0][RW-1:0]     rem;
    logic [2:0][QW-1:0]     num;
    logic [2:0][QW-1:0]     quo;
  } tun_div_t;

endpackage

FILE: src/tun_sqrt_cell.sv
module tun_sqrt_cell import tun_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  tun_sqrt_t din,
  output tun_sqrt_t dout
);

  tun_sqrt_t nxt;
  logic [RW+2:0] rem2;
  logic [RW+2:0] trial;

  // one root bit per cell
  always_comb begin
    nxt   = din;
    rem2  = {din.rem[RW:0], din.rad[SW-1 -: 2]};
    trial = {1'b0, din.root, 2'b01};
    if (rem2 >= trial) begin
      nxt.rem  = rem2 - trial;
      nxt.root = {din.root[RW-2:0], 1'b1};
    end else begin
      nxt.rem  = rem2;
      nxt.root = {din.root[RW-2:0], 1'b0};
    end
    nxt.rad = {din.rad[SW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: src/tun_div_cell.sv
module tun_div_cell import tun_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  tun_div_t din,
  output tun_div_t dout
);

  tun_div_t nxt;
  logic [RW:0] r2;

  // one quotient bit per cell for each lane
  always_comb begin
    nxt = din;
    r2  = '0;
    for (int k = 0; k < 3; k++) begin
      r2 = {din.rem[k], din.num[k][QW-1]};
      if (r2 >= {1'b0, din.den}) begin
        r2         = r2 - {1'b0, din.den};
        nxt.quo[k] = {din.quo[k][QW-2:0], 1'b1};
      end else begin
        nxt.quo[k] = {din.quo[k][QW-2:0], 1'b0};
      end
      nxt.rem[k] = r2[RW-1:0];
      nxt.num[k] = {din.num[k][QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: src/triangle_unit_normal_core.sv
// Unit face normal of a triangle, Q7.8 vertices in, Q1.14 normal out.
// Throughput: one triangle per cycle; the pipeline moves as one while the
// output word is not held, one root bit and one quotient bit per cell.
// Reset: synchronous, clears every valid bit; data registers are not reset.
module triangle_unit_normal_core import tun_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] p1_x,
  input  logic signed [CW-1:0] p1_y,
  input  logic signed [CW-1:0] p1_z,
  input  logic signed [CW-1:0] p2_x,
  input  logic signed [CW-1:0] p2_y,
  input  logic signed [CW-1:0] p2_z,
  input  logic signed [CW-1:0] p3_x,
  input  logic signed [CW-1:0] p3_y,
  input  logic signed [CW-1:0] p3_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [OW-1:0] normal_x,
  output logic signed [OW-1:0] normal_y,
  output logic signed [OW-1:0] normal_z,
  output logic                 degenerate
);

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage registers
  logic                       v1, v2, v3, v4, v5, v6;
  logic signed [5:0][EW-1:0]  edg;
  logic signed [5:0][2*EW-1:0] prd;
  logic [2:0]                 neg3, neg4, neg5, neg6;
  logic [2:0][PW-1:0]         mag3, mag4;
  logic [5:0]                 pos4;
  logic                       dg4, dg5, dg6;
  logic [2:0][MW-1:0]         m5, m6;
  logic [2:0][2*MW-1:0]       sq6;

  tun_sqrt_t sq_in;
  tun_sqrt_t sq_pipe [RW+1];
  tun_div_t  dv_pipe [QW+1];

  // edge vectors
  logic signed [5:0][EW-1:0] edg_next;
  always_comb begin
    edg_next[0] = EW'(p2_x) - EW'(p1_x);
    edg_next[1] = EW'(p2_y) - EW'(p1_y);
    edg_next[2] = EW'(p2_z) - EW'(p1_z);
    edg_next[3] = EW'(p3_x) - EW'(p1_x);
    edg_next[4] = EW'(p3_y) - EW'(p1_y);
    edg_next[5] = EW'(p3_z) - EW'(p1_z);
  end

  // cross product terms
  logic signed [5:0][2*EW-1:0] prd_next;
  always_comb begin
    prd_next[0] = $signed(edg[1]) * $signed(edg[5]);
    prd_next[1] = $signed(edg[2]) * $signed(edg[4]);
    prd_next[2] = $signed(edg[2]) * $signed(edg[3]);
    prd_next[3] = $signed(edg[0]) * $signed(edg[5]);
    prd_next[4] = $signed(edg[0]) * $signed(edg[4]);
    prd_next[5] = $signed(edg[1]) * $signed(edg[3]);
  end

  // cross components as sign and magnitude
  logic [2:0]         neg_next;
  logic [2:0][PW-1:0] mag_next;
  always_comb begin
    logic signed [2*EW:0] c;
    c = '0;
    for (int k = 0; k < 3; k++) begin
      c = (2*EW+1)'($signed(prd[2*k])) - (2*EW+1)'($signed(prd[2*k+1]));
      neg_next[k] = c[2*EW];
      mag_next[k] = c[2*EW] ? PW'(-c) : PW'(c);
    end
  end

  // largest magnitude and its leading one
  logic [PW-1:0] mx;
  logic [5:0]    pos_next;
  always_comb begin
    mx = mag3[0];
    if (mag3[1] > mx) mx = mag3[1];
    if (mag3[2] > mx) mx = mag3[2];
    pos_next = '0;
    for (int i = 0; i < PW; i++) begin
      if (mx[i]) pos_next = 6'(i);
    end
  end

  // normalize so the largest sits in [2^29, 2^30)
  logic [2:0][MW-1:0] m_next;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos4 >= 6'(MW-1)) begin
        m_next[k] = MW'(mag4[k] >> (pos4 - 6'(MW-1)));
      end else begin
        m_next[k] = MW'(mag4[k] << (6'(MW-1) - pos4));
      end
    end
  end

  // squares, then sum into the root chain
  logic [2:0][2*MW-1:0] sq_next;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_next[k] = (2*MW)'(m5[k]) * (2*MW)'(m5[k]);
    end
    sq_in.vld   = v6;
    sq_in.degen = dg6;
    sq_in.neg   = neg6;
    sq_in.mag   = m6;
    sq_in.rad   = SW'(sq6[0]) + SW'(sq6[1]) + SW'(sq6[2]);
    sq_in.rem   = '0;
    sq_in.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      sq_pipe[0].vld <= 1'b0;
    end else if (en) begin
      v1   <= in_valid;
      edg  <= edg_next;
      v2   <= v1;
      prd  <= prd_next;
      v3   <= v2;
      neg3 <= neg_next;
      mag3 <= mag_next;
      v4   <= v3;
      neg4 <= neg3;
      mag4 <= mag3;
      pos4 <= pos_next;
      dg4  <= (mx == '0);
      v5   <= v4;
      neg5 <= neg4;
      dg5  <= dg4;
      m5   <= m_next;
      v6   <= v5;
      neg6 <= neg5;
      dg6  <= dg5;
      m6   <= m5;
      sq6  <= sq_next;
      sq_pipe[0] <= sq_in;
    end
  end

  // square root chain
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (sq_pipe[i]),
      .dout (sq_pipe[i+1])
    );
  end

  // rounded numerators for the dividers
  tun_div_t dv_in;
  always_comb begin
    logic [NW-1:0] n;
    n = '0;
    dv_in.vld   = sq_pipe[RW].vld;
    dv_in.degen = sq_pipe[RW].degen;
    dv_in.neg   = sq_pipe[RW].neg;
    dv_in.den   = sq_pipe[RW].root;
    for (int k = 0; k < 3; k++) begin
      n = {1'b0, sq_pipe[RW].mag[k], FB'(0)} + NW'(sq_pipe[RW].root >> 1);
      dv_in.rem[k] = RW'(n[NW-1:QW]);
      dv_in.num[k] = n[QW-1:0];
      dv_in.quo[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_pipe[0].vld <= 1'b0;
    end else if (en) begin
      dv_pipe[0] <= dv_in;
    end
  end

  // divider chain, three lanes per cell
  for (genvar i = 0; i < QW; i++) begin : g_div
    tun_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (dv_pipe[i]),
      .dout (dv_pipe[i+1])
    );
  end

  // clamp, sign and output word
  logic [2:0][OW-1:0] nrm_next;
  always_comb begin
    logic [QW-1:0] q;
    q = '0;
    for (int k = 0; k < 3; k++) begin
      q = (dv_pipe[QW].quo[k] > ONE_Q) ? ONE_Q : dv_pipe[QW].quo[k];
      if (dv_pipe[QW].degen) begin
        nrm_next[k] = '0;
      end else if (dv_pipe[QW].neg[k]) begin
        nrm_next[k] = -OW'(q);
      end else begin
        nrm_next[k] = OW'(q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid  <= dv_pipe[QW].vld;
      normal_x   <= nrm_next[0];
      normal_y   <= nrm_next[1];
      normal_z   <= nrm_next[2];
      degenerate <= dv_pipe[QW].degen;
    end
  end

endmodule
